// File: design/mud_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mud_pkg;

   // Width of each operand and result field on the stream ports
   localparam int FIELD_W = 32;

   // Stream payload widths: two fields packed back to back
   localparam int REQ_DATA_W = 2 * FIELD_W;
   localparam int RSP_DATA_W = 2 * FIELD_W;

   // Number of operand bits that one byte count selects, clamped to the field
   function automatic int operand_bits(input int bytes);
      int bits;
      bits = bytes * 8;
      return (bits > FIELD_W) ? FIELD_W : bits;
   endfunction

endpackage

`default_nettype wire

// File: design/mud_core.sv
`timescale 1ns / 1ps
`default_nettype none

module mud_core #(
   parameter int DVD_W = 32,
   parameter int DVS_W = 32
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  idle,
   output logic                  done,
   input  wire logic             take,
   output logic [DVD_W-1:0]      quotient,
   output logic [DVS_W-1:0]      remainder,
   output logic                  divide_ok
);

   localparam int CNT_W = $clog2(DVD_W);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic             ok_ff;

   logic [DVS_W:0]   rem_shift;
   logic [DVS_W+1:0] trial;
   logic             fits;

   // Shift the next dividend bit into the partial remainder and try the subtract
   assign rem_shift = {rem_ff, quo_ff[DVD_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign fits      = ~trial[DVS_W+1];

   // Sequence one quotient bit per cycle, most significant first
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  quo_ff   <= dividend;
                  rem_ff   <= '0;
                  dvs_ff   <= divisor;
                  ok_ff    <= (divisor != '0);
                  cnt_ff   <= CNT_W'(DVD_W - 1);
                  state_ff <= S_RUN;
               end
            end
            S_RUN: begin
               quo_ff <= {quo_ff[DVD_W-2:0], fits};
               rem_ff <= fits ? trial[DVS_W-1:0] : rem_shift[DVS_W-1:0];
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign idle      = (state_ff == S_IDLE);
   assign done      = (state_ff == S_DONE);
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign divide_ok = ok_ff;

endmodule

`default_nettype wire

// File: design/multiword_unsigned_divider_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Unsigned divider: each request beat carries a dividend and a divisor and
// returns one response beat with the floor quotient, the remainder and a
// divide_ok flag; a zero divisor gives divide_ok low with quotient and
// remainder zero. Operands use only their low DIVIDEND_BYTES*8 and
// DIVISOR_BYTES*8 bits (at most 32). The divider is a bit-serial restoring
// unit that produces one quotient bit per cycle; each item passes through a
// load step, one step per dividend bit and a step that moves the result
// into the response register before the next request can be taken. The
// response register lets the next request start while a finished result
// waits for rsp_tready. One item is worked on at a time.
module multiword_unsigned_divider_unit #(
   parameter int DIVIDEND_BYTES = 4,
   parameter int DIVISOR_BYTES  = 4
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request: dividend [31:0], divisor [63:32]
   input  wire logic [mud_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // Response: quotient [31:0], remainder [63:32]
   output logic [mud_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // Response user: divide_ok [0]
   output logic                                 rsp_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready
);

   localparam int DVD_W = mud_pkg::operand_bits(DIVIDEND_BYTES);
   localparam int DVS_W = mud_pkg::operand_bits(DIVISOR_BYTES);

   logic             core_idle;
   logic             core_done;
   logic             core_take;
   logic             core_start;
   logic [DVD_W-1:0] core_quo;
   logic [DVS_W-1:0] core_rem;
   logic             core_ok;

   logic [mud_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [mud_pkg::RSP_DATA_W-1:0] rsp_data_in;
   logic                           rsp_ok_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_free;

   // Accept a request beat only while the divider is free
   assign req_tready = core_idle;
   assign core_start = req_tvalid & core_idle;

   mud_core #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (core_start),
      .dividend  (req_tdata[DVD_W-1:0]),
      .divisor   (req_tdata[mud_pkg::FIELD_W+DVS_W-1:mud_pkg::FIELD_W]),
      .idle      (core_idle),
      .done      (core_done),
      .take      (core_take),
      .quotient  (core_quo),
      .remainder (core_rem),
      .divide_ok (core_ok)
   );

   // Hand the result over once the response register is empty or draining
   assign rsp_free  = ~rsp_valid_ff | rsp_tready;
   assign core_take = core_done & rsp_free;

   // Zero both fields on division by zero
   always_comb begin
      if (core_ok) begin
         rsp_data_in = {mud_pkg::FIELD_W'(core_rem), mud_pkg::FIELD_W'(core_quo)};
      end else begin
         rsp_data_in = '0;
      end
   end

   // Hold the response beat until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_take) begin
         rsp_valid_ff <= 1'b1;
         rsp_data_ff  <= rsp_data_in;
         rsp_ok_ff    <= core_ok;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ok_ff;

`ifndef NO_ASSERTIONS
   // The divider goes busy right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("divider still free after accepting a request");

   // A failed divide carries zero quotient and remainder
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("nonzero payload on division by zero");

   // A finished result stays parked while the response register is blocked
   assert property (@(posedge clock) disable iff (reset)
      core_done && rsp_tvalid && !rsp_tready |=> core_done && !req_tready)
      else $error("finished result left the divider while output was blocked");
`endif

endmodule

`default_nettype wire
